@@ rtl/pgri_pkg.sv @@
// Shared constants, codes and types of the Poisson grid check block.
// No dependencies; imported by every module under rtl/.
`default_nettype none

package pgri_pkg;

  // Grid geometry
  localparam int GRID_SIDE_MAX    = 64;
  localparam int NEIGHBOUR_RADIUS = 5;
  localparam int CELL_COUNT       = GRID_SIDE_MAX * GRID_SIDE_MAX;
  localparam int ADDR_W           = $clog2(CELL_COUNT);
  localparam int IDX_W            = $clog2(GRID_SIDE_MAX);
  localparam int SIDE_W           = $clog2(GRID_SIDE_MAX + 1);
  localparam int SPAN             = 2 * NEIGHBOUR_RADIUS + 1;
  localparam int SPAN_W           = $clog2(SPAN);
  localparam int NB_W             = ((IDX_W > SPAN_W) ? IDX_W : SPAN_W) + 2;

  // Field and register widths
  localparam int CAND_W   = 18;  // signed Q2.16 input coordinate
  localparam int COORD_W  = 17;  // in-square coordinate 0..1.0
  localparam int MIN_W    = 35;
  localparam int INV_W    = 24;
  localparam int GRID_W   = 7;
  localparam int CELL_W   = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W   = COORD_W + INV_W;
  localparam int MAP_IDX_W = PROD_W - 32;
  localparam int SQ_W     = 33;  // square of a difference of at most 1.0

  localparam logic signed [CAND_W-1:0] ONE_Q16 = 18'sd65536;

  // Operation codes carried in s_tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Register reset values
  localparam logic [MIN_W-1:0]  SPACING_SQ_RST    = '0;
  localparam logic [INV_W-1:0]  INV_CELL_SIZE_RST = 24'd4194304;
  localparam logic [GRID_W-1:0] GRID_CELLS_RST    = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPACING_SQ    = 2'd0,
    REG_INV_CELL_SIZE = 2'd1,
    REG_GRID_CELLS    = 2'd2
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_TOO_CLOSE = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  // One grid cell: valid mark plus the stored point
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } cell_word_t;

endpackage

`default_nettype wire

@@ rtl/poisson_grid_reject_insert.sv @@
// Top level of the Poisson-disk background grid check: sequencer, cell memory,
// config registers and stream ports. Depends on pgri_pkg, pgri_cell_map and
// pgri_dist_unit.
`default_nettype none

// Takes one beat at a time. A candidate inside the unit square is mapped to
// its cell on one shared multiplier, x then y plus the done handoff, then
// the 11x11 neighborhood is scanned one cell per cycle out of the
// single-read-port cell memory, the distance pipe drains, the decide state
// stores an accepted point and the result state loads the output register;
// a new beat is taken only after the result of the last one is loaded.
// A candidate outside the square goes from accept straight to the result
// state. A clear beat, and likewise the pass after reset, writes every one
// of the 4096 cells once since the valid marks live in the same memory as
// the points; no beat is taken during that pass, config writes are. Config
// writes are always ready and must only happen while the block is idle.
// Result beats sit in an output register, so a stalled sink holds the block
// only at the end of the following item.

module poisson_grid_reject_insert
  import pgri_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // cand_x [17:0], cand_y [35:18], zero pad
  input  logic                 s_tuser,   // operation [0]
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // cell_col [5:0], cell_row [11:6], zero pad
  output logic [STATUS_W-1:0]  m_tuser,   // status [1:0]
  // config writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MIN_W-1:0]     cfg_data
);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,  // memory clear after reset
    S_IDLE   = 8'b0000_0010,
    S_MAP    = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_DRAIN  = 8'b0001_0000,
    S_DECIDE = 8'b0010_0000,
    S_CLEAR  = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t state;

  // config
  logic [MIN_W-1:0]  spacing_sq;
  logic [INV_W-1:0]  inv_cell_size;
  logic [GRID_W-1:0] grid_cells;
  logic [SIDE_W-1:0] side;
  logic [IDX_W-1:0]  side_m1;

  // candidate
  logic signed [CAND_W-1:0] in_x;
  logic signed [CAND_W-1:0] in_y;
  logic                     outside;
  logic [COORD_W-1:0]       cx;
  logic [COORD_W-1:0]       cy;

  // mapping
  logic             map_start;
  logic             map_done;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] row;

  // scan
  logic [SPAN_W-1:0] di;
  logic [SPAN_W-1:0] dj;
  logic [NB_W-1:0]   ni;
  logic [NB_W-1:0]   nj;
  logic              in_grid;
  logic              close;
  logic              hit;
  logic [1:0]        drain;

  // cell memory
  cell_word_t        mem [CELL_COUNT];
  cell_word_t        rd_data;
  logic              rd_en;
  logic              rd_ok;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  cell_word_t        wr_data;
  logic [ADDR_W-1:0] sweep;

  // result
  status_t           res_status;
  logic [CELL_W-1:0] res_col;
  logic [CELL_W-1:0] res_row;

  logic s_beat;

  assign s_tready  = (state == S_IDLE);
  assign s_beat    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // ---- config registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_sq    <= SPACING_SQ_RST;
      inv_cell_size <= INV_CELL_SIZE_RST;
      grid_cells    <= GRID_CELLS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPACING_SQ:    spacing_sq    <= cfg_data;
        REG_INV_CELL_SIZE: inv_cell_size <= cfg_data[INV_W-1:0];
        REG_GRID_CELLS:    grid_cells    <= cfg_data[GRID_W-1:0];
        default: ;  // no register there
      endcase
    end
  end

  // effective grid side, 1..GRID_SIDE_MAX
  always_comb begin
    if (grid_cells == '0) begin
      side = SIDE_W'(1);
    end else if (int'(grid_cells) > GRID_SIDE_MAX) begin
      side = SIDE_W'(GRID_SIDE_MAX);
    end else begin
      side = SIDE_W'(grid_cells);
    end
  end
  assign side_m1 = IDX_W'(side - SIDE_W'(1));

  // ---- input decode ----
  assign in_x    = $signed(s_tdata[CAND_W-1:0]);
  assign in_y    = $signed(s_tdata[2*CAND_W-1:CAND_W]);
  assign outside = in_x[CAND_W-1] || in_y[CAND_W-1] || (in_x > ONE_Q16) || (in_y > ONE_Q16);

  always_ff @(posedge clk) begin
    if (s_beat) begin
      cx <= in_x[COORD_W-1:0];
      cy <= in_y[COORD_W-1:0];
    end
  end

  pgri_cell_map u_map (
    .clk           (clk),
    .rst           (rst),
    .start         (map_start),
    .x             (cx),
    .y             (cy),
    .inv_cell_size (inv_cell_size),
    .side_m1       (side_m1),
    .done          (map_done),
    .col           (col),
    .row           (row)
  );

  // ---- neighborhood address ----
  assign ni      = NB_W'(col) - NB_W'(NEIGHBOUR_RADIUS) + NB_W'(di);
  assign nj      = NB_W'(row) - NB_W'(NEIGHBOUR_RADIUS) + NB_W'(dj);
  assign in_grid = !ni[NB_W-1] && (ni < NB_W'(side)) && !nj[NB_W-1] && (nj < NB_W'(side));
  assign rd_en   = (state == S_SCAN) && in_grid;
  assign rd_addr = ADDR_W'(int'(nj[IDX_W-1:0]) * GRID_SIDE_MAX + int'(ni[IDX_W-1:0]));

  // ---- memory write port: clear sweep or insert ----
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep;
    wr_data = '0;
    if (state == S_INIT || state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == S_DECIDE && !close) begin
      wr_en         = 1'b1;
      wr_addr       = ADDR_W'(int'(row) * GRID_SIDE_MAX + int'(col));
      wr_data.valid = 1'b1;
      wr_data.x     = cx;
      wr_data.y     = cy;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= rd_en;
    end
  end

  pgri_dist_unit u_dist (
    .clk        (clk),
    .rst        (rst),
    .en         (rd_ok),
    .stored     (rd_data),
    .cand_x     (cx),
    .cand_y     (cy),
    .spacing_sq (spacing_sq),
    .hit        (hit)
  );

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep     <= '0;
      map_start <= 1'b0;
      di        <= '0;
      dj        <= '0;
      drain     <= '0;
      close     <= 1'b0;
    end else begin
      map_start <= 1'b0;
      if (hit) close <= 1'b1;
      case (state)
        S_INIT, S_CLEAR: begin
          sweep <= sweep + ADDR_W'(1);
          if (int'(sweep) == CELL_COUNT - 1) begin
            sweep <= '0;
            state <= (state == S_INIT) ? S_IDLE : S_RESULT;
          end
        end
        S_IDLE: begin
          if (s_beat) begin
            if (s_tuser == OP_CLEAR) begin
              state <= S_CLEAR;
            end else if (outside) begin
              state <= S_RESULT;
            end else begin
              state     <= S_MAP;
              map_start <= 1'b1;
            end
          end
        end
        S_MAP: begin
          if (map_done) begin
            state <= S_SCAN;
            di    <= '0;
            dj    <= '0;
            close <= 1'b0;
          end
        end
        S_SCAN: begin
          if (int'(dj) == SPAN - 1) begin
            dj <= '0;
            if (int'(di) == SPAN - 1) begin
              state <= S_DRAIN;
              drain <= '0;
            end else begin
              di <= di + SPAN_W'(1);
            end
          end else begin
            dj <= dj + SPAN_W'(1);
          end
        end
        S_DRAIN: begin
          // read register and square stage still in flight
          drain <= drain + 2'd1;
          if (drain == 2'd1) state <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---- result fields ----
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_col    <= '0;
        res_row    <= '0;
        res_status <= (s_tuser == OP_CLEAR) ? ST_CLEARED : ST_OUTSIDE;
      end
      S_DECIDE: begin
        res_col    <= CELL_W'(col);
        res_row    <= CELL_W'(row);
        res_status <= close ? ST_TOO_CLOSE : ST_ACCEPTED;
      end
      default: ;
    endcase
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_RESULT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'b0, res_row, res_col};
      m_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pgri_cell_map.sv @@
// Maps a candidate to its grid cell with one multiplier used for x, then y.
// Depends on pgri_pkg.
`default_nettype none

module pgri_cell_map
  import pgri_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] x,
  input  logic [COORD_W-1:0] y,
  input  logic [INV_W-1:0]   inv_cell_size,
  input  logic [IDX_W-1:0]   side_m1,
  output logic               done,
  output logic [IDX_W-1:0]   col,
  output logic [IDX_W-1:0]   row
);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_COL  = 3'b010,
    M_ROW  = 3'b100
  } map_state_t;

  map_state_t           state;
  logic [COORD_W-1:0]   mul_a;
  logic [PROD_W-1:0]    prod;
  logic [MAP_IDX_W-1:0] idx;
  logic [IDX_W-1:0]     idx_clamped;

  assign mul_a = (state == M_COL) ? y : x;
  assign idx   = prod[PROD_W-1:32];

  always_comb begin
    if (idx > MAP_IDX_W'(side_m1)) begin
      idx_clamped = side_m1;
    end else begin
      idx_clamped = IDX_W'(idx);
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(inv_cell_size);
    if (state == M_COL) col <= idx_clamped;
    if (state == M_ROW) row <= idx_clamped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) state <= M_COL;
        end
        M_COL: begin
          state <= M_ROW;
        end
        M_ROW: begin
          state <= M_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/pgri_dist_unit.sv @@
// Squared-distance compare of one stored cell against the candidate.
// Two-stage: squares registered, then sum and compare. Depends on pgri_pkg.
`default_nettype none

module pgri_dist_unit
  import pgri_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  cell_word_t         stored,
  input  logic [COORD_W-1:0] cand_x,
  input  logic [COORD_W-1:0] cand_y,
  input  logic [MIN_W-1:0]   spacing_sq,
  output logic               hit
);

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic signed [2*COORD_W+1:0] dx2;
  logic signed [2*COORD_W+1:0] dy2;
  logic [SQ_W-1:0]             sq_x;
  logic [SQ_W-1:0]             sq_y;
  logic                        sq_ok;
  logic [SQ_W:0]               d2;

  assign dx  = $signed({1'b0, stored.x}) - $signed({1'b0, cand_x});
  assign dy  = $signed({1'b0, stored.y}) - $signed({1'b0, cand_y});
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;

  always_ff @(posedge clk) begin
    sq_x <= dx2[SQ_W-1:0];
    sq_y <= dy2[SQ_W-1:0];
  end

  // only occupied cells count
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_ok <= 1'b0;
    end else begin
      sq_ok <= en && stored.valid;
    end
  end

  assign d2  = {1'b0, sq_x} + {1'b0, sq_y};
  assign hit = sq_ok && (MIN_W'(d2) < spacing_sq);

endmodule

`default_nettype wire
